// ----- rtl/fsio_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fsio_pkg;

	// Width of the signed impulse amplitude
	localparam int PULSE_W = 5;

	localparam logic signed [PULSE_W-1:0] PULSE_ZERO    = 5'sd0;
	localparam logic signed [PULSE_W-1:0] PULSE_POS_BIG = 5'sd10;
	localparam logic signed [PULSE_W-1:0] PULSE_POS_SML = 5'sd5;
	localparam logic signed [PULSE_W-1:0] PULSE_NEG_BIG = -5'sd10;
	localparam logic signed [PULSE_W-1:0] PULSE_NEG_SML = -5'sd5;

endpackage

`default_nettype wire

// ----- rtl/fsio_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fsio_front #(
	parameter int PHASE_BITS = 24,
	parameter int BREAK_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [PHASE_BITS-1:0]     phase_step,
	input  wire logic [BREAK_BITS-1:0]     break_first,
	input  wire logic [BREAK_BITS-1:0]     break_second,
	input  wire logic                      s2_ready,
	output logic                           valid_s1,
	output logic [PHASE_BITS-1:0]          phase_s1,
	output logic [BREAK_BITS-1:0]          a_s1,
	output logic [2*BREAK_BITS-1:0]        ab_s1,
	output logic [2*BREAK_BITS:0]          nab_s1
);

	logic                    s1_ready;
	logic                    accept;
	logic [PHASE_BITS-1:0]   phase_acc_q;
	logic [BREAK_BITS:0]     one_minus_a;

	assign s1_ready = !valid_s1 || s2_ready;
	assign in_stall = !s1_ready;
	assign accept   = in_valid && s1_ready;

	// 1 - a in Q0.BREAK_BITS, one bit wider to hold a full cycle
	assign one_minus_a = {1'b1, {BREAK_BITS{1'b0}}} - {1'b0, break_first};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_acc_q <= '0;
		end else begin
			if (s1_ready)
				valid_s1 <= in_valid;
			if (accept)
				phase_acc_q <= phase_acc_q + phase_step;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_s1   <= break_first;
			ab_s1  <= break_first * break_second;
			nab_s1 <= one_minus_a * {1'b0, break_second};
		end
	end

	// The accumulator always holds the phase of the transaction in this stage
	assign phase_s1 = phase_acc_q;

endmodule

`default_nettype wire

// ----- rtl/fsio_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fsio_back
	import fsio_pkg::*;
#(
	parameter int PHASE_BITS = 24,
	parameter int BREAK_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid_s1,
	input  wire logic [PHASE_BITS-1:0]         phase_s1,
	input  wire logic [BREAK_BITS-1:0]         a_s1,
	input  wire logic [2*BREAK_BITS-1:0]       ab_s1,
	input  wire logic [2*BREAK_BITS:0]         nab_s1,
	output logic                               s2_ready,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [PULSE_W-1:0]          pulse_value
);

	localparam int SH  = 2*BREAK_BITS - PHASE_BITS;
	localparam int SHR = (SH > 0) ? SH : 0;
	localparam int SHL = (SH < 0) ? -SH : 0;
	localparam int TW  = 2*BREAK_BITS + 1;
	localparam int CW  = PHASE_BITS + 1;
	localparam logic [TW-1:0] RND = TW'((64'd1 << SHR) - 64'd1);

	typedef enum logic [1:0] {ST_RISE, ST_HOLD, ST_FALL, ST_TAIL} stage_t;

	// Round a Q0.(2*BREAK_BITS) threshold up to phase units
	function automatic logic [CW-1:0] to_units(input logic [TW-1:0] t);
		logic [TW-1:0] r;
		begin
			r = (t + RND) >> SHR;
			to_units = CW'(r) << SHL;
		end
	endfunction

	stage_t                    stage_q;
	stage_t                    stage_nx;
	logic signed [PULSE_W-1:0] pulse_nx;
	logic [CW-1:0]             c1, c2, c3, ph;
	logic [TW-1:0]             t2, t3;

	assign t2 = {1'b0, a_s1, {BREAK_BITS{1'b0}}};
	assign t3 = t2 + nab_s1;
	assign c1 = to_units({1'b0, ab_s1});
	assign c2 = to_units(t2);
	assign c3 = to_units(t3);
	assign ph = {1'b0, phase_s1};

	always_comb begin
		stage_nx = stage_q;
		pulse_nx = PULSE_ZERO;
		case (stage_q)
			ST_RISE: begin
				if (ph < c1) begin
					stage_nx = ST_HOLD;
					pulse_nx = PULSE_POS_BIG;
				end
			end
			ST_HOLD: begin
				if (ph >= c1 && ph < c2) begin
					stage_nx = ST_FALL;
					pulse_nx = PULSE_POS_SML;
				end
			end
			ST_FALL: begin
				if (ph >= c2 && ph < c3) begin
					stage_nx = ST_TAIL;
					pulse_nx = PULSE_NEG_BIG;
				end
			end
			default: begin
				if (ph >= c3) begin
					stage_nx = ST_RISE;
					pulse_nx = PULSE_NEG_SML;
				end
			end
		endcase
	end

	assign s2_ready = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= ST_RISE;
			out_valid   <= 1'b0;
			pulse_value <= PULSE_ZERO;
		end else if (s2_ready) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				stage_q     <= stage_nx;
				pulse_value <= pulse_nx;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/four_stage_impulse_oscillator_unit.sv -----
// Four-stage impulse oscillator. Each input transaction carries a phase step
// and two breakpoints a and b; the block advances a wrapping Q0.PHASE_BITS
// phase, derives the windows a*b, a and a+(1-a)*b, and returns exactly one
// result transaction holding +10, +5, -10, -5 or 0 as the stage machine fires
// or waits. One transaction is taken every clock cycle when the output side
// does not stall. The register behind the two breakpoint multipliers takes
// the input when it is accepted, and the output register behind the
// threshold compare and stage update takes the result from it once the
// output side has room. Phase and stage reset to zero.
`timescale 1ns / 1ps
`default_nettype none

module four_stage_impulse_oscillator_unit
	import fsio_pkg::*;
#(
	parameter int PHASE_BITS = 24,
	parameter int BREAK_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [PHASE_BITS-1:0]     phase_step,
	input  wire logic [BREAK_BITS-1:0]     break_first,
	input  wire logic [BREAK_BITS-1:0]     break_second,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [PULSE_W-1:0]      pulse_value
);

	// Stage 1 -> stage 2 transfer
	logic                      valid_s1;
	logic                      s2_ready;
	logic [PHASE_BITS-1:0]     phase_s1;
	logic [BREAK_BITS-1:0]     a_s1;
	logic [2*BREAK_BITS-1:0]   ab_s1;
	logic [2*BREAK_BITS:0]     nab_s1;

	// Phase accumulate and breakpoint products
	fsio_front #(
		.PHASE_BITS(PHASE_BITS),
		.BREAK_BITS(BREAK_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.phase_step   (phase_step),
		.break_first  (break_first),
		.break_second (break_second),
		.s2_ready     (s2_ready),
		.valid_s1     (valid_s1),
		.phase_s1     (phase_s1),
		.a_s1         (a_s1),
		.ab_s1        (ab_s1),
		.nab_s1       (nab_s1)
	);

	// Thresholds, window compare, stage machine and result register
	fsio_back #(
		.PHASE_BITS(PHASE_BITS),
		.BREAK_BITS(BREAK_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.phase_s1    (phase_s1),
		.a_s1        (a_s1),
		.ab_s1       (ab_s1),
		.nab_s1      (nab_s1),
		.s2_ready    (s2_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pulse_value (pulse_value)
	);

endmodule

`default_nettype wire
